// ----- rtl/assert_macros.svh -----
// Assertion helpers for the clipper. Empty under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PCLIP_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define PCLIP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define PCLIP_ASSERT_IMPLY(lbl, ante, cons, msg)
`define PCLIP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/pclip_pkg.sv -----
package pclip_pkg;

   localparam int COORD_WIDTH        = 32;
   localparam int MAX_ATTRIBUTES_DEF = 8;
   localparam int DIST_WIDTH         = 2 * COORD_WIDTH;
   localparam int T_FRAC             = 32;
   localparam int T_WIDTH            = T_FRAC + 1;
   localparam int ACNT_WIDTH         = 4;
   localparam int COUNT_WIDTH        = 32;
   localparam int CSR_IDX_WIDTH      = 3;
   localparam int CSR_DATA_WIDTH     = 32;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_PLANE_A    = 3'd0,
      CSR_PLANE_B    = 3'd1,
      CSR_PLANE_C    = 3'd2,
      CSR_PLANE_D    = 3'd3,
      CSR_ATTR_COUNT = 3'd4
   } csr_index_type;

   localparam logic IN_POS  = 1'b0;
   localparam logic IN_ATTR = 1'b1;

   typedef enum logic [1:0] {
      OUT_POS  = 2'd0,
      OUT_ATTR = 2'd1,
      OUT_MARK = 2'd2
   } out_kind_type;

   typedef struct packed {
      logic                          kind;
      logic signed [COORD_WIDTH-1:0] comp_0;
      logic signed [COORD_WIDTH-1:0] comp_1;
      logic signed [COORD_WIDTH-1:0] comp_2;
      logic signed [COORD_WIDTH-1:0] comp_3;
      logic                          polygon_end;
   } req_type;

   typedef struct packed {
      logic [1:0]                    out_kind;
      logic signed [COORD_WIDTH-1:0] out_comp_0;
      logic signed [COORD_WIDTH-1:0] out_comp_1;
      logic signed [COORD_WIDTH-1:0] out_comp_2;
      logic signed [COORD_WIDTH-1:0] out_comp_3;
      logic                          run_last;
   } rsp_type;

   typedef struct packed {
      logic                         valid;
      logic signed [DIST_WIDTH-1:0] value;
   } dist_result_type;

   typedef struct packed {
      logic               done;
      logic [T_WIDTH-1:0] t;
   } div_result_type;

endpackage

// ----- rtl/pclip_dist.sv -----
// Plane distance: four multiplier lanes, then a two-level merge with saturation.
module pclip_dist (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        start,
   input  logic signed [pclip_pkg::COORD_WIDTH-1:0]    pos   [4],
   input  logic signed [pclip_pkg::COORD_WIDTH-1:0]    plane [4],
   output pclip_pkg::dist_result_type                  result
);
   localparam int W  = pclip_pkg::COORD_WIDTH;
   localparam int DW = pclip_pkg::DIST_WIDTH;
   localparam int S  = 2 * W + 2;
   localparam logic signed [S-1:0] DMAX = {{(S-DW+1){1'b0}}, {(DW-1){1'b1}}};
   localparam logic signed [S-1:0] DMIN = {{(S-DW+1){1'b1}}, {(DW-1){1'b0}}};

   logic                     v1_ff, v2_ff;
   logic signed [2*W-1:0]    prod_ff [4];
   logic signed [2*W:0]      s01_ff, s23_ff;
   logic signed [S-1:0]      sum;
   pclip_pkg::dist_result_type result_ff, result_in;

   always_comb begin
      sum = S'(s01_ff) + S'(s23_ff);
      result_in.valid = v2_ff;
      if (sum > DMAX) begin
         result_in.value = DMAX[DW-1:0];
      end else if (sum < DMIN) begin
         result_in.value = DMIN[DW-1:0];
      end else begin
         result_in.value = sum[DW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff           <= 1'b0;
         v2_ff           <= 1'b0;
         result_ff.valid <= 1'b0;
      end else begin
         v1_ff     <= start;
         v2_ff     <= v1_ff;
         result_ff <= result_in;
      end
      for (int k = 0; k < 4; k++) begin
         prod_ff[k] <= pos[k] * plane[k];
      end
      s01_ff <= (2*W+1)'(prod_ff[0]) + (2*W+1)'(prod_ff[1]);
      s23_ff <= (2*W+1)'(prod_ff[2]) + (2*W+1)'(prod_ff[3]);
   end

   assign result = result_ff;

endmodule

// ----- rtl/pclip_div.sv -----
// Restoring divider, one quotient bit per cycle: t = num / den as Q1.32, 1.0 when num >= den.
module pclip_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [pclip_pkg::DIST_WIDTH-1:0] num,
   input  logic [pclip_pkg::DIST_WIDTH-1:0] den,
   output pclip_pkg::div_result_type        result
);
   localparam int DW = pclip_pkg::DIST_WIDTH;
   localparam int TW = pclip_pkg::T_WIDTH;
   localparam int FR = pclip_pkg::T_FRAC;
   localparam int CNTW = $clog2(FR);

   logic            busy_ff, busy_in, done_ff, done_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0]   rem_ff, rem_in, den_ff, den_in, sh;
   logic [TW-1:0]   q_ff, q_in;
   logic            take;

   always_comb begin
      sh      = {rem_ff[DW-2:0], 1'b0};
      take    = rem_ff[DW-1] || (sh >= den_ff);
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      if (start) begin
         den_in = den;
         if (num >= den) begin
            q_in    = TW'(1) << FR;
            done_in = 1'b1;
         end else begin
            rem_in  = num;
            q_in    = '0;
            busy_in = 1'b1;
            cnt_in  = CNTW'(FR - 1);
         end
      end else if (busy_ff) begin
         rem_in = take ? sh - den_ff : sh;
         q_in   = {q_ff[TW-2:0], take};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
   end

   assign result.done = done_ff;
   assign result.t    = q_ff;

endmodule

// ----- rtl/pclip_lane.sv -----
// One interpolation lane: a + (b - a) * t, magnitude rounded half away from zero.
module pclip_lane (
   input  logic                                     clock,
   input  logic                                     en,
   input  logic signed [pclip_pkg::COORD_WIDTH-1:0] a,
   input  logic signed [pclip_pkg::COORD_WIDTH-1:0] b,
   input  logic [pclip_pkg::T_WIDTH-1:0]            t,
   output logic signed [pclip_pkg::COORD_WIDTH-1:0] res
);
   localparam int W  = pclip_pkg::COORD_WIDTH;
   localparam int TW = pclip_pkg::T_WIDTH;
   localparam int FR = pclip_pkg::T_FRAC;
   localparam int PW = W + 1 + TW;

   logic signed [W:0]   diff;
   logic [W:0]          mag;
   logic [PW-1:0]       prod_ff;
   logic [PW:0]         rnd;
   logic signed [W-1:0] a_ff;
   logic                neg_ff;
   logic [W-1:0]        m;

   always_comb begin
      diff = $signed({b[W-1], b}) - $signed({a[W-1], a});
      mag  = diff[W] ? (W+1)'(-diff) : (W+1)'(diff);
      rnd  = {1'b0, prod_ff} + ((PW+1)'(1) << (FR - 1));
      m    = rnd[FR +: W];
      res  = neg_ff ? a_ff - $signed(m) : a_ff + $signed(m);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= PW'(mag) * PW'(t);
         a_ff    <= a;
         neg_ff  <= diff[W];
      end
   end

endmodule

// ----- rtl/polygon_plane_clipper_unit.sv -----
// Channel  Ports                        Transaction
// req      req_valid/req_stall/req_data one position or attribute triple
// rsp      rsp_valid/rsp_stall/rsp_data one output row or end marker
// csr      csr_we/csr_index/csr_wdata   register write, no wait
//
// One input transaction at a time; req_stall is high until its results are queued.
// An item that completes no vertex needs only S_IDLE. Completing a vertex adds the distance
// pipeline (S_DSTART, S_DIST), then per edge the inside test (S_EDGE), the bit-serial divider
// (S_DIV) if the edge crosses the plane, and S_RD, S_MUL, S_OUT per output row (rsp_stall can
// hold S_OUT). Closing a polygon adds S_CLOSE before its edge test and S_MARK for the marker.
// Synchronous active-high reset; the vertex memory needs no clearing.
`include "assert_macros.svh"

module polygon_plane_clipper_unit #(
   parameter int MAX_ATTRIBUTES = pclip_pkg::MAX_ATTRIBUTES_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  pclip_pkg::req_type                    req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output pclip_pkg::rsp_type                    rsp_data,
   input  logic                                  csr_we,
   input  logic [pclip_pkg::CSR_IDX_WIDTH-1:0]   csr_index,
   input  logic [pclip_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);
   localparam int W     = pclip_pkg::COORD_WIDTH;
   localparam int DW    = pclip_pkg::DIST_WIDTH;
   localparam int TW    = pclip_pkg::T_WIDTH;
   localparam int CW    = pclip_pkg::COUNT_WIDTH;
   localparam int ROWS  = MAX_ATTRIBUTES + 1;
   localparam int DEPTH = 3 * ROWS;
   localparam int AW    = $clog2(DEPTH);
   localparam int RW    = $clog2(ROWS + 1);
   localparam logic [TW-1:0] T_ONE = TW'(1) << pclip_pkg::T_FRAC;

   typedef enum logic [3:0] {
      S_IDLE, S_DSTART, S_DIST, S_CLOSE, S_EDGE, S_DIV, S_RD, S_MUL, S_OUT, S_MARK
   } state_type;

   function automatic logic [AW-1:0] addr_of(input logic [1:0] bank, input logic [RW-1:0] row);
      return AW'(int'(bank) * ROWS + int'(row));
   endfunction

   function automatic logic [1:0] free_bank(input logic [1:0] x, input logic [1:0] y);
      logic [1:0] r;
      if (x != 2'd0 && y != 2'd0) begin
         r = 2'd0;
      end else if (x != 2'd1 && y != 2'd1) begin
         r = 2'd1;
      end else begin
         r = 2'd2;
      end
      return r;
   endfunction

   state_type state_ff, state_in;
   logic signed [W-1:0]  plane_ff [4];
   logic [pclip_pkg::ACNT_WIDTH-1:0] acnt_ff;
   logic [1:0]    first_ptr_ff, first_ptr_in, prev_ptr_ff, prev_ptr_in, cur_ptr_ff, cur_ptr_in;
   logic [RW-1:0] first_cnt_ff, first_cnt_in, prev_cnt_ff, prev_cnt_in, cur_cnt_ff, cur_cnt_in;
   logic signed [DW-1:0] first_d_ff, first_d_in, prev_d_ff, prev_d_in;
   logic          have_first_ff, have_first_in, open_ff, open_in, pend_ff, pend_in;
   logic [RW-1:0] idx_ff, idx_in;
   logic [CW-1:0] emitted_ff, emitted_in;
   logic signed [W-1:0] cur_pos_ff [4];
   logic signed [W-1:0] cur_pos_in [4];
   logic [1:0]    ea_ptr_ff, ea_ptr_in, eb_ptr_ff, eb_ptr_in, p0_ptr_ff, p0_ptr_in;
   logic [1:0]    p1_ptr_ff, p1_ptr_in;
   logic [RW-1:0] ea_cnt_ff, ea_cnt_in, eb_cnt_ff, eb_cnt_in, p0_cnt_ff, p0_cnt_in;
   logic [RW-1:0] p1_cnt_ff, p1_cnt_in, row_ff, row_in;
   logic signed [DW-1:0] da_ff, da_in, db_ff, db_in;
   logic          closing_ff, closing_in, ina_ff, ina_in, cross_ff, cross_in, lerp_ff, lerp_in;
   logic          rsp_valid_ff, rsp_valid_in;
   pclip_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [4*W-1:0] vmem [DEPTH];
   logic [4*W-1:0] rd_a_ff, rd_b_ff, wdata;
   logic [AW-1:0]  waddr;
   logic           mem_we;

   logic          req_acc, rsp_free, store, go_complete, ina, inb, last_row;
   logic [RW-1:0] n;
   logic          dist_start, div_start;
   logic [DW-1:0] div_num, div_den;
   logic          mask_a, mask_b;
   logic signed [W-1:0] lane_a [4];
   logic signed [W-1:0] lane_b [4];
   logic signed [W-1:0] lane_res [4];
   pclip_pkg::dist_result_type dist_res;
   pclip_pkg::div_result_type  div_res;

   assign req_stall = (state_ff != S_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign n         = (int'(acnt_ff) > MAX_ATTRIBUTES) ? RW'(MAX_ATTRIBUTES) : RW'(acnt_ff);
   assign mask_a    = (row_ff <= p0_cnt_ff);
   assign mask_b    = (row_ff <= p1_cnt_ff);
   assign last_row  = (row_ff == n);
   assign ina       = (da_ff > 0);
   assign inb       = (db_ff > 0);
   assign div_num   = ina ? da_ff : db_ff;
   assign div_den   = div_num - (ina ? db_ff : da_ff);

   pclip_dist u_dist (
      .clock (clock), .reset (reset), .start (dist_start),
      .pos (cur_pos_ff), .plane (plane_ff), .result (dist_res)
   );

   pclip_div u_div (
      .clock (clock), .reset (reset), .start (div_start),
      .num (div_num), .den (div_den), .result (div_res)
   );

   for (genvar k = 0; k < 4; k++) begin : g_lane
      assign lane_a[k] = mask_a ? $signed(rd_a_ff[k*W +: W]) : '0;
      assign lane_b[k] = mask_b ? $signed(rd_b_ff[k*W +: W]) : '0;
      pclip_lane u_lane (
         .clock (clock), .en (state_ff == S_MUL), .a (lane_a[k]), .b (lane_b[k]),
         .t (div_res.t), .res (lane_res[k])
      );
   end

   always_comb begin
      state_in      = state_ff;
      first_ptr_in  = first_ptr_ff;
      prev_ptr_in   = prev_ptr_ff;
      cur_ptr_in    = cur_ptr_ff;
      first_cnt_in  = first_cnt_ff;
      prev_cnt_in   = prev_cnt_ff;
      cur_cnt_in    = cur_cnt_ff;
      first_d_in    = first_d_ff;
      prev_d_in     = prev_d_ff;
      have_first_in = have_first_ff;
      open_in       = open_ff;
      pend_in       = pend_ff;
      idx_in        = idx_ff;
      emitted_in    = emitted_ff;
      cur_pos_in    = cur_pos_ff;
      ea_ptr_in     = ea_ptr_ff;
      eb_ptr_in     = eb_ptr_ff;
      p0_ptr_in     = p0_ptr_ff;
      p1_ptr_in     = p1_ptr_ff;
      ea_cnt_in     = ea_cnt_ff;
      eb_cnt_in     = eb_cnt_ff;
      p0_cnt_in     = p0_cnt_ff;
      p1_cnt_in     = p1_cnt_ff;
      row_in        = row_ff;
      da_in         = da_ff;
      db_in         = db_ff;
      closing_in    = closing_ff;
      ina_in        = ina_ff;
      cross_in      = cross_ff;
      lerp_in       = lerp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      mem_we        = 1'b0;
      waddr         = addr_of(cur_ptr_ff, '0);
      wdata         = {req_data.comp_3, req_data.comp_2, req_data.comp_1, req_data.comp_0};
      store         = 1'b0;
      go_complete   = 1'b0;
      dist_start    = 1'b0;
      div_start     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               pend_in = req_data.polygon_end;
               if (req_data.kind == pclip_pkg::IN_POS) begin
                  mem_we        = 1'b1;
                  cur_pos_in[0] = req_data.comp_0;
                  cur_pos_in[1] = req_data.comp_1;
                  cur_pos_in[2] = req_data.comp_2;
                  cur_pos_in[3] = req_data.comp_3;
                  cur_cnt_in    = '0;
                  idx_in        = '0;
                  open_in       = 1'b1;
                  go_complete   = (n == '0);
               end else if (open_ff) begin
                  store = (idx_ff < n);
                  if (store) begin
                     mem_we     = 1'b1;
                     waddr      = addr_of(cur_ptr_ff, idx_ff + 1'b1);
                     wdata      = {{W{1'b0}}, req_data.comp_2, req_data.comp_1,
                                   req_data.comp_0};
                     cur_cnt_in = idx_ff + 1'b1;
                     idx_in     = idx_ff + 1'b1;
                  end
                  go_complete = ((idx_ff + RW'(store)) >= n);
               end
               if (go_complete) begin
                  open_in  = 1'b0;
                  state_in = S_DSTART;
               end else if (req_data.polygon_end) begin
                  state_in = S_CLOSE;
               end
            end
         end
         S_DSTART: begin
            dist_start = 1'b1;
            state_in   = S_DIST;
         end
         S_DIST: begin
            if (dist_res.valid) begin
               prev_ptr_in = cur_ptr_ff;
               prev_cnt_in = cur_cnt_ff;
               prev_d_in   = dist_res.value;
               if (!have_first_ff) begin
                  first_ptr_in  = cur_ptr_ff;
                  first_cnt_in  = cur_cnt_ff;
                  first_d_in    = dist_res.value;
                  have_first_in = 1'b1;
                  cur_ptr_in    = free_bank(cur_ptr_ff, cur_ptr_ff);
                  state_in      = pend_ff ? S_CLOSE : S_IDLE;
               end else begin
                  ea_ptr_in  = prev_ptr_ff;
                  ea_cnt_in  = prev_cnt_ff;
                  da_in      = prev_d_ff;
                  eb_ptr_in  = cur_ptr_ff;
                  eb_cnt_in  = cur_cnt_ff;
                  db_in      = dist_res.value;
                  closing_in = 1'b0;
                  cur_ptr_in = free_bank(first_ptr_ff, cur_ptr_ff);
                  state_in   = S_EDGE;
               end
            end
         end
         S_CLOSE: begin
            if (have_first_ff) begin
               ea_ptr_in  = prev_ptr_ff;
               ea_cnt_in  = prev_cnt_ff;
               da_in      = prev_d_ff;
               eb_ptr_in  = first_ptr_ff;
               eb_cnt_in  = first_cnt_ff;
               db_in      = first_d_ff;
               closing_in = 1'b1;
               state_in   = S_EDGE;
            end else begin
               state_in = S_MARK;
            end
         end
         S_EDGE: begin
            ina_in   = ina;
            cross_in = (ina != inb);
            row_in   = '0;
            p0_ptr_in = ea_ptr_ff;
            p0_cnt_in = ea_cnt_ff;
            lerp_in   = 1'b0;
            if (ina != inb) begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end else if (ina) begin
               state_in = S_RD;
            end else begin
               state_in = closing_ff ? S_MARK : (pend_ff ? S_CLOSE : S_IDLE);
            end
         end
         S_DIV: begin
            if (div_res.done) begin
               state_in = S_RD;
               if (!ina_ff) begin
                  // inside endpoint is the edge end
                  lerp_in   = 1'b1;
                  p0_ptr_in = eb_ptr_ff;
                  p0_cnt_in = eb_cnt_ff;
                  p1_ptr_in = ea_ptr_ff;
                  p1_cnt_in = ea_cnt_ff;
               end
            end
         end
         S_RD: begin
            state_in = S_MUL;
         end
         S_MUL: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_free) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.out_kind = (row_ff == '0) ? pclip_pkg::OUT_POS : pclip_pkg::OUT_ATTR;
               rsp_data_in.out_comp_0 = lerp_ff ? lane_res[0] : lane_a[0];
               rsp_data_in.out_comp_1 = lerp_ff ? lane_res[1] : lane_a[1];
               rsp_data_in.out_comp_2 = lerp_ff ? lane_res[2] : lane_a[2];
               rsp_data_in.out_comp_3 = (row_ff != '0) ? '0 :
                                        (lerp_ff ? lane_res[3] : lane_a[3]);
               rsp_data_in.run_last = last_row && (lerp_ff || !cross_ff) && !pend_ff;
               if (last_row) begin
                  emitted_in = emitted_ff + 1'b1;
                  if (!lerp_ff && cross_ff) begin
                     lerp_in   = 1'b1;
                     row_in    = '0;
                     p0_ptr_in = ea_ptr_ff;
                     p0_cnt_in = ea_cnt_ff;
                     p1_ptr_in = eb_ptr_ff;
                     p1_cnt_in = eb_cnt_ff;
                     state_in  = S_RD;
                  end else begin
                     state_in = closing_ff ? S_MARK : (pend_ff ? S_CLOSE : S_IDLE);
                  end
               end else begin
                  row_in   = row_ff + 1'b1;
                  state_in = S_RD;
               end
            end
         end
         S_MARK: begin
            if (rsp_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.out_kind   = pclip_pkg::OUT_MARK;
               rsp_data_in.out_comp_0 = $signed(emitted_ff);
               rsp_data_in.out_comp_1 = '0;
               rsp_data_in.out_comp_2 = '0;
               rsp_data_in.out_comp_3 = '0;
               rsp_data_in.run_last   = 1'b1;
               emitted_in    = '0;
               have_first_in = 1'b0;
               first_d_in    = '0;
               prev_d_in     = '0;
               open_in       = 1'b0;
               idx_in        = '0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         for (int k = 0; k < 4; k++) begin
            plane_ff[k] <= '0;
         end
         acnt_ff       <= '0;
         first_ptr_ff  <= 2'd0;
         prev_ptr_ff   <= 2'd0;
         cur_ptr_ff    <= 2'd1;
         first_d_ff    <= '0;
         prev_d_ff     <= '0;
         have_first_ff <= 1'b0;
         open_ff       <= 1'b0;
         pend_ff       <= 1'b0;
         idx_ff        <= '0;
         emitted_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         first_ptr_ff  <= first_ptr_in;
         prev_ptr_ff   <= prev_ptr_in;
         cur_ptr_ff    <= cur_ptr_in;
         first_d_ff    <= first_d_in;
         prev_d_ff     <= prev_d_in;
         have_first_ff <= have_first_in;
         open_ff       <= open_in;
         pend_ff       <= pend_in;
         idx_ff        <= idx_in;
         emitted_ff    <= emitted_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               pclip_pkg::CSR_PLANE_A:    plane_ff[0] <= $signed(csr_wdata[W-1:0]);
               pclip_pkg::CSR_PLANE_B:    plane_ff[1] <= $signed(csr_wdata[W-1:0]);
               pclip_pkg::CSR_PLANE_C:    plane_ff[2] <= $signed(csr_wdata[W-1:0]);
               pclip_pkg::CSR_PLANE_D:    plane_ff[3] <= $signed(csr_wdata[W-1:0]);
               pclip_pkg::CSR_ATTR_COUNT: acnt_ff <= csr_wdata[pclip_pkg::ACNT_WIDTH-1:0];
               default: begin
               end
            endcase
         end
      end
      first_cnt_ff <= first_cnt_in;
      prev_cnt_ff  <= prev_cnt_in;
      cur_cnt_ff   <= cur_cnt_in;
      cur_pos_ff   <= cur_pos_in;
      ea_ptr_ff    <= ea_ptr_in;
      eb_ptr_ff    <= eb_ptr_in;
      p0_ptr_ff    <= p0_ptr_in;
      p1_ptr_ff    <= p1_ptr_in;
      ea_cnt_ff    <= ea_cnt_in;
      eb_cnt_ff    <= eb_cnt_in;
      p0_cnt_ff    <= p0_cnt_in;
      p1_cnt_ff    <= p1_cnt_in;
      row_ff       <= row_in;
      da_ff        <= da_in;
      db_ff        <= db_in;
      closing_ff   <= closing_in;
      ina_ff       <= ina_in;
      cross_ff     <= cross_in;
      lerp_ff      <= lerp_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // three vertex banks, rows = position then attribute triples
   always_ff @(posedge clock) begin
      if (mem_we) begin
         vmem[waddr] <= wdata;
      end
      rd_a_ff <= vmem[addr_of(p0_ptr_ff, row_ff)];
      rd_b_ff <= vmem[addr_of(p1_ptr_ff, row_ff)];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `PCLIP_ASSERT_IMPLY(a_cur_bank_free, state_ff == S_IDLE, (cur_ptr_ff != first_ptr_ff) && (cur_ptr_ff != prev_ptr_ff), "current bank aliases a live vertex")
   `PCLIP_ASSERT_IMPLY(a_t_range, (state_ff == S_MUL) && lerp_ff, div_res.t <= T_ONE, "interpolation factor out of range")
   `PCLIP_ASSERT_IMPLY(a_mark_last, rsp_valid_ff && (rsp_data_ff.out_kind == pclip_pkg::OUT_MARK), rsp_data_ff.run_last, "marker without run_last")
   `PCLIP_ASSERT_NEXT(a_mark_done, (state_ff == S_MARK) && rsp_free, (state_ff == S_IDLE) && !have_first_ff && (emitted_ff == '0), "polygon state not cleared after marker")

endmodule
